// File: design/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// shared types and constants of the integer pixel replication upscaler
// ----------------------------------------------------------------------------
package ipru_pkg;

    // frame limits
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIXEL_BITS  = 32;
    localparam int MIN_FACTOR  = 2;
    localparam int MAX_FACTOR  = 8;

    // field widths
    localparam int CFG_W       = 11;
    localparam int FACTOR_W    = 4;
    localparam int INDEX_W     = 26;
    localparam int CFG_INDEX_W = 2;

    // derived widths
    localparam int WCL_W   = $clog2(MAX_WIDTH + 1);
    localparam int HCL_W   = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int LINE_W  = $clog2(MAX_WIDTH * MAX_FACTOR + 1);
    localparam int SKIP_W  = $clog2(MAX_WIDTH * (MAX_FACTOR * MAX_FACTOR - MAX_FACTOR) + 1);
    localparam int STEP_W  = $clog2(MAX_FACTOR);

    // job queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0]    RST_SRC_WIDTH    = 11'd160;
    localparam logic [CFG_W-1:0]    RST_SRC_HEIGHT   = 11'd120;
    localparam logic [FACTOR_W-1:0] RST_SCALE_FACTOR = 4'd2;

    // configuration as written
    typedef struct packed {
        logic [CFG_W-1:0]    src_width;
        logic [CFG_W-1:0]    src_height;
        logic [FACTOR_W-1:0] scale_factor;
    } cfg_t;

    // one classified pixel, ready for replication
    typedef struct packed {
        logic [INDEX_W-1:0]    base;
        logic [PIXEL_BITS-1:0] pixel;
        logic [STEP_W-1:0]     last_step;   // factor minus one
        logic [LINE_W-1:0]     line;        // destination line pitch
        logic                  frame_last;
    } job_t;

    // queue status toward the back end
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: design/ipru_front.sv
// ----------------------------------------------------------------------------
// ipru_front
// accepts source pixels, tracks raster position and builds replication jobs
// ----------------------------------------------------------------------------
module ipru_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipru_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic [ipru_pkg::PIXEL_BITS-1:0] pixel_value,
    output ipru_pkg::job_t                job
);

    logic [ipru_pkg::COL_W-1:0]   column_count_reg, column_count_next;
    logic [ipru_pkg::ROW_W-1:0]   row_count_reg, row_count_next;
    logic [ipru_pkg::INDEX_W-1:0] dest_base_reg, dest_base_next;

    logic [ipru_pkg::WCL_W-1:0]    w;
    logic [ipru_pkg::HCL_W-1:0]    h;
    logic [ipru_pkg::FACTOR_W-1:0] f;
    logic [5:0]                    kf;
    logic [ipru_pkg::LINE_W-1:0]   line;
    logic [ipru_pkg::SKIP_W-1:0]   skip;
    logic                          last_col, last_row;

    // f*f - f, the line skip factor at the end of a source line
    function automatic logic [5:0] skip_factor(input logic [ipru_pkg::FACTOR_W-1:0] fv);
        logic [7:0] sq;
        sq = 8'(fv) * 8'(fv) - 8'(fv);
        return sq[5:0];
    endfunction

    always_comb
    begin
        if (cfg.src_width == '0)
            w = ipru_pkg::WCL_W'(1);
        else if (int'(cfg.src_width) > ipru_pkg::MAX_WIDTH)
            w = ipru_pkg::WCL_W'(ipru_pkg::MAX_WIDTH);
        else
            w = ipru_pkg::WCL_W'(cfg.src_width);

        if (cfg.src_height == '0)
            h = ipru_pkg::HCL_W'(1);
        else if (int'(cfg.src_height) > ipru_pkg::MAX_HEIGHT)
            h = ipru_pkg::HCL_W'(ipru_pkg::MAX_HEIGHT);
        else
            h = ipru_pkg::HCL_W'(cfg.src_height);

        if (int'(cfg.scale_factor) < ipru_pkg::MIN_FACTOR)
            f = ipru_pkg::FACTOR_W'(ipru_pkg::MIN_FACTOR);
        else if (int'(cfg.scale_factor) > ipru_pkg::MAX_FACTOR)
            f = ipru_pkg::FACTOR_W'(ipru_pkg::MAX_FACTOR);
        else
            f = cfg.scale_factor;
    end

    assign kf   = skip_factor(f);
    assign line = ipru_pkg::LINE_W'(w) * ipru_pkg::LINE_W'(f);
    assign skip = ipru_pkg::SKIP_W'(w) * ipru_pkg::SKIP_W'(kf);

    assign last_col = ((ipru_pkg::WCL_W + 1)'(column_count_reg) + 1'b1)
                      >= (ipru_pkg::WCL_W + 1)'(w);
    assign last_row = ((ipru_pkg::HCL_W + 1)'(row_count_reg) + 1'b1)
                      >= (ipru_pkg::HCL_W + 1)'(h);

    always_comb
    begin
        job.base       = dest_base_reg;
        job.pixel      = pixel_value;
        job.last_step  = ipru_pkg::STEP_W'(f - 1'b1);
        job.line       = line;
        job.frame_last = last_col && last_row;

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        dest_base_next    = dest_base_reg;
        if (accept)
        begin
            if (last_col)
            begin
                column_count_next = '0;
                if (last_row)
                begin
                    row_count_next = '0;
                    dest_base_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + 1'b1;
                    dest_base_next = dest_base_reg + ipru_pkg::INDEX_W'(f)
                                     + ipru_pkg::INDEX_W'(skip);
                end
            end
            else
            begin
                column_count_next = column_count_reg + 1'b1;
                dest_base_next    = dest_base_reg + ipru_pkg::INDEX_W'(f);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            dest_base_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            dest_base_reg    <= dest_base_next;
        end
    end

endmodule

// File: design/ipru_job_queue.sv
// ----------------------------------------------------------------------------
// ipru_job_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
module ipru_job_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  ipru_pkg::job_t          wr_job,
    input  logic                    rd_en,
    output ipru_pkg::job_t          rd_job,
    output ipru_pkg::queue_status_t status
);

    ipru_pkg::job_t slot_reg [ipru_pkg::QUEUE_DEPTH];

    logic [ipru_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ipru_pkg::QCNT_W-1:0] count_reg;

    assign status.full  = (count_reg == ipru_pkg::QCNT_W'(ipru_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rd_job       = slot_reg[rd_ptr_reg];

    // slots hold payload only
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (int'(wr_ptr_reg) == ipru_pkg::QUEUE_DEPTH - 1)
                              ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (int'(rd_ptr_reg) == ipru_pkg::QUEUE_DEPTH - 1)
                              ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: design/ipru_back.sv
// ----------------------------------------------------------------------------
// ipru_back
// walks the factor-by-factor block of the head job, one write per cycle while the result word is taken
// ----------------------------------------------------------------------------
module ipru_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ipru_pkg::job_t                    job,
    input  logic                              job_valid,
    output logic                              job_done,
    input  logic                              pop,
    output logic                              empty,
    output logic [ipru_pkg::INDEX_W-1:0]      dest_index,
    output logic [ipru_pkg::PIXEL_BITS-1:0]   write_value,
    output logic                              run_last,
    output logic                              frame_end
);

    logic [ipru_pkg::STEP_W-1:0]  col_step_reg, col_step_next;
    logic [ipru_pkg::STEP_W-1:0]  row_step_reg, row_step_next;
    logic [ipru_pkg::SKIP_W-1:0]  row_off_reg, row_off_next;
    logic                         out_valid_reg;
    logic [ipru_pkg::INDEX_W-1:0] index_reg;
    logic [ipru_pkg::PIXEL_BITS-1:0] value_reg;
    logic                         run_last_reg, frame_end_reg;

    logic advance, issue, row_wrap, col_wrap;

    // output word moves on when the slot is free or being taken
    assign advance  = !out_valid_reg || pop;
    assign issue    = advance && job_valid;
    assign row_wrap = (row_step_reg == job.last_step);
    assign col_wrap = (col_step_reg == job.last_step);
    assign job_done = issue && row_wrap && col_wrap;

    always_comb
    begin
        col_step_next = col_step_reg;
        row_step_next = row_step_reg;
        row_off_next  = row_off_reg;
        if (issue)
        begin
            if (row_wrap)
            begin
                row_step_next = '0;
                row_off_next  = '0;
                col_step_next = col_wrap ? '0 : col_step_reg + 1'b1;
            end
            else
            begin
                row_step_next = row_step_reg + 1'b1;
                row_off_next  = row_off_reg + ipru_pkg::SKIP_W'(job.line);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_step_reg  <= '0;
            row_step_reg  <= '0;
            row_off_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_step_reg <= col_step_next;
            row_step_reg <= row_step_next;
            row_off_reg  <= row_off_next;
            if (advance)
                out_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            index_reg     <= job.base + ipru_pkg::INDEX_W'(col_step_reg)
                             + ipru_pkg::INDEX_W'(row_off_reg);
            value_reg     <= job.pixel;
            run_last_reg  <= row_wrap && col_wrap;
            frame_end_reg <= row_wrap && col_wrap && job.frame_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign dest_index  = index_reg;
    assign write_value = value_reg;
    assign run_last    = run_last_reg;
    assign frame_end   = frame_end_reg;

endmodule

// File: design/integer_pixel_replication_upscaler_unit.sv
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler_unit
// nearest-neighbor integer upscaler: one source pixel in, factor^2 writes out
// ----------------------------------------------------------------------------
// source pixels enter in raster order through a push/full port and each one
// leaves as factor*factor destination writes through an empty/pop port,
// column offset outer and row offset inner, the last write of each pixel
// flagged by run_last and the last write of the frame also by frame_end;
// the output side gives one write per clock while writes are popped, set
// by the single write slot of the back end; the front end classifies a
// pixel in its accept cycle and a four-entry job queue lets it take up to
// four pixels ahead of the writes; the first write of a pixel reaches the
// result ports through the job queue and the output register of the back
// end; registers take effect on the next pixel, and the user, not the
// block, sees that they are written only while the block is idle
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_write,
    input  logic [ipru_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ipru_pkg::CFG_W-1:0]          cfg_data,
    // source pixel words
    input  logic                                push,
    output logic                                full,
    input  logic [ipru_pkg::PIXEL_BITS-1:0]     pixel_value,
    // destination write words
    output logic                                empty,
    input  logic                                pop,
    output logic [ipru_pkg::INDEX_W-1:0]        dest_index,
    output logic [ipru_pkg::PIXEL_BITS-1:0]     write_value,
    output logic                                run_last,
    output logic                                frame_end
);

    ipru_pkg::cfg_t          cfg_reg;
    ipru_pkg::job_t          front_job, head_job;
    ipru_pkg::queue_status_t q_status;

    logic accept;
    logic job_done;

    // register file: writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width    <= ipru_pkg::RST_SRC_WIDTH;
            cfg_reg.src_height   <= ipru_pkg::RST_SRC_HEIGHT;
            cfg_reg.scale_factor <= ipru_pkg::RST_SCALE_FACTOR;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ipru_pkg::REG_SRC_WIDTH:    cfg_reg.src_width    <= cfg_data;
                ipru_pkg::REG_SRC_HEIGHT:   cfg_reg.src_height   <= cfg_data;
                ipru_pkg::REG_SCALE_FACTOR: cfg_reg.scale_factor <=
                                                cfg_data[ipru_pkg::FACTOR_W-1:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // a pixel is taken whenever the job queue has room
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    // raster position and job build
    ipru_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .pixel_value (pixel_value),
        .job         (front_job)
    );

    // decouples pixel intake from write issue
    ipru_job_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .rd_en  (job_done),
        .rd_job (head_job),
        .status (q_status)
    );

    // block walk and output register
    ipru_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (head_job),
        .job_valid   (!q_status.empty),
        .job_done    (job_done),
        .pop         (pop),
        .empty       (empty),
        .dest_index  (dest_index),
        .write_value (write_value),
        .run_last    (run_last),
        .frame_end   (frame_end)
    );

endmodule

// File: design/ipru_checker.sv
// ----------------------------------------------------------------------------
// ipru_checker
// port-level checks of the upscaler, bound to the top level
// ----------------------------------------------------------------------------
module ipru_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                full,
    input logic                                empty,
    input logic                                pop,
    input logic [ipru_pkg::INDEX_W-1:0]        dest_index,
    input logic [ipru_pkg::PIXEL_BITS-1:0]     write_value,
    input logic                                run_last,
    input logic                                frame_end
);

    // frame end only on the closing write of a pixel
    a_frame_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_end) |-> run_last)
        else $error("frame_end without run_last");

    // a stalled result word holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dest_index) && $stable(write_value)
                              && $stable(run_last) && $stable(frame_end)))
        else $error("result word changed while stalled");

    // inside a run the next write follows at once with the same pixel
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_last) |=> (!empty && $stable(write_value)))
        else $error("run broken before its last write");

    // out of reset nothing is waiting and intake is open
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("block not clean after reset");

endmodule

bind integer_pixel_replication_upscaler_unit ipru_checker u_ipru_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer pixel replication upscaler
// ----------------------------------------------------------------------------
// source pixels go in through the push/full port. Each accepted pixel is
// expanded by a scoreboard into its factor-by-factor block of expected
// destination writes. Every write popped from the block is compared field by
// field with the oldest expected one. Registers are rewritten between phases
// once all writes have drained: first a directed part (out-of-range sizes and
// factors, single-pixel frames, mid-frame size changes), then random phases
// with bursty idling on both ports.
// ----------------------------------------------------------------------------
module tb;

    // unmapped register slot, writes there must be ignored
    localparam logic [ipru_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int PIXEL_TARGET = 420;  // number of source pixels sent in all
    localparam int QUIET_TAIL   = 60;   // final pixels sent with no idling
    localparam int MAX_REPORTS  = 40;   // mismatch lines printed before going silent

    // one destination write as seen on the result ports
    typedef struct packed {
        logic [ipru_pkg::INDEX_W-1:0]    dest_index;
        logic [ipru_pkg::PIXEL_BITS-1:0] write_value;
        logic                            run_last;
        logic                            frame_end;
    } dest_write_t;

    // ------------------------------------------------------------------------
    // scoreboard: replication predictor plus queue of expected writes
    // ------------------------------------------------------------------------
    class upscale_scoreboard;
        logic [ipru_pkg::CFG_W-1:0]    width_reg;
        logic [ipru_pkg::CFG_W-1:0]    height_reg;
        logic [ipru_pkg::FACTOR_W-1:0] factor_reg;
        logic [9:0]                    column_count;
        logic [9:0]                    row_count;
        logic [ipru_pkg::INDEX_W-1:0]  dest_base;
        dest_write_t                   expected_writes[$];
        int                            errors;

        function new();
            width_reg    = ipru_pkg::RST_SRC_WIDTH;
            height_reg   = ipru_pkg::RST_SRC_HEIGHT;
            factor_reg   = ipru_pkg::RST_SCALE_FACTOR;
            column_count = '0;
            row_count    = '0;
            dest_base    = '0;
            errors       = 0;
        endfunction

        function void set_register(logic [ipru_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [ipru_pkg::CFG_W-1:0] data);
            case (idx)
                ipru_pkg::REG_SRC_WIDTH:    width_reg  = data;
                ipru_pkg::REG_SRC_HEIGHT:   height_reg = data;
                ipru_pkg::REG_SCALE_FACTOR: factor_reg = data[ipru_pkg::FACTOR_W-1:0];
                default: ;
            endcase
        endfunction

        // expand one accepted pixel into its block of writes
        function void note_pixel(logic [ipru_pkg::PIXEL_BITS-1:0] pixel);
            int unsigned w, h, f, pitch;
            bit          last_col, last_row;
            dest_write_t wr;
            w = 32'(width_reg);
            h = 32'(height_reg);
            f = 32'(factor_reg);
            if (w < 1) w = 1;
            if (w > ipru_pkg::MAX_WIDTH) w = ipru_pkg::MAX_WIDTH;
            if (h < 1) h = 1;
            if (h > ipru_pkg::MAX_HEIGHT) h = ipru_pkg::MAX_HEIGHT;
            if (f < ipru_pkg::MIN_FACTOR) f = ipru_pkg::MIN_FACTOR;
            if (f > ipru_pkg::MAX_FACTOR) f = ipru_pkg::MAX_FACTOR;
            pitch    = w * f;
            last_col = (int'(column_count) + 1 >= w);
            last_row = (int'(row_count) + 1 >= h);
            // column offset outer, row offset inner
            for (int unsigned i = 0; i < f; i++) begin
                for (int unsigned j = 0; j < f; j++) begin
                    wr.dest_index  = ipru_pkg::INDEX_W'(dest_base + i + j * pitch);
                    wr.write_value = pixel;
                    wr.run_last    = (i + 1 == f) && (j + 1 == f);
                    wr.frame_end   = wr.run_last && last_col && last_row;
                    expected_writes.push_back(wr);
                end
            end
            // advance position, skipping the replicated lines at a line end
            dest_base = ipru_pkg::INDEX_W'(dest_base + f);
            if (last_col) begin
                column_count = '0;
                dest_base    = ipru_pkg::INDEX_W'(dest_base + pitch * (f - 1));
                if (last_row) begin
                    row_count = '0;
                    dest_base = '0;
                end
                else begin
                    row_count = row_count + 1'b1;
                end
            end
            else begin
                column_count = column_count + 1'b1;
            end
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_REPORTS)
                $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_write(input dest_write_t got);
            dest_write_t want;
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write index %0h value %0h",
                                          got.dest_index, got.write_value));
                return;
            end
            want = expected_writes.pop_front();
            if (got.dest_index !== want.dest_index)
                report_mismatch($sformatf("dest_index %0h, expected %0h",
                                          got.dest_index, want.dest_index));
            if (got.write_value !== want.write_value)
                report_mismatch($sformatf("write_value %0h, expected %0h at index %0h",
                                          got.write_value, want.write_value, want.dest_index));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, expected %b at index %0h",
                                          got.run_last, want.run_last, want.dest_index));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, expected %b at index %0h",
                                          got.frame_end, want.frame_end, want.dest_index));
        endtask

        function int outstanding();
            return expected_writes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_write;
    logic [ipru_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ipru_pkg::CFG_W-1:0]       cfg_data;
    logic                             push;
    logic                             full;
    logic [ipru_pkg::PIXEL_BITS-1:0]  pixel_value;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [ipru_pkg::INDEX_W-1:0]     dest_index;
    logic [ipru_pkg::PIXEL_BITS-1:0]  write_value;
    logic                             run_last;
    logic                             frame_end;

    upscale_scoreboard sb = new();

    // idling knobs, changed per phase
    int push_gap_pct = 0;
    int pop_stall_pct = 0;
    int pop_hold = 0;

    integer_pixel_replication_upscaler_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .empty       (empty),
        .pop         (pop),
        .dest_index  (dest_index),
        .write_value (write_value),
        .run_last    (run_last),
        .frame_end   (frame_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // result side: pop with random stall bursts of idle cycles
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if ($urandom_range(0, 99) < pop_stall_pct) begin
            pop      <= 1'b0;
            pop_hold <= $urandom_range(0, 2);
        end
        else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the edge that completes them
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (push && !full)
                sb.note_pixel(pixel_value);
            if (pop && !empty)
                sb.check_write('{dest_index, write_value, run_last, frame_end});
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // hold one pixel on the port until the block takes it
    task automatic send_pixel(input logic [ipru_pkg::PIXEL_BITS-1:0] value);
        if ($urandom_range(0, 99) < push_gap_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push        <= 1'b1;
        pixel_value <= value;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // stop sending and wait until every expected write has come out
    task automatic wait_for_drain();
        push <= 1'b0;
        // let the monitor note the last accepted pixel first
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        // settle time past the pipeline before touching registers
        repeat (4) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(input logic [ipru_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ipru_pkg::CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic close_writes();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [ipru_pkg::CFG_W-1:0] w,
                             input logic [ipru_pkg::CFG_W-1:0] h,
                             input logic [ipru_pkg::CFG_W-1:0] f);
        wait_for_drain();
        write_reg(ipru_pkg::REG_SRC_WIDTH, w);
        write_reg(ipru_pkg::REG_SRC_HEIGHT, h);
        write_reg(ipru_pkg::REG_SCALE_FACTOR, f);
        close_writes();
    endtask

    // full-range pixels with some zero-extended 16-bit ones and extremes
    function automatic logic [ipru_pkg::PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return {16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // mostly tiny frames so lines and frames wrap often, some out of range
    function automatic logic [ipru_pkg::CFG_W-1:0] random_extent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ipru_pkg::CFG_W'($urandom_range(ipru_pkg::MAX_WIDTH + 1, 2047));
            2:       return ipru_pkg::CFG_W'($urandom_range(7, ipru_pkg::MAX_WIDTH));
            default: return ipru_pkg::CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int sent;
        int batch;

        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        push        <= 1'b0;
        pixel_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_gap_pct  = 20;
        pop_stall_pct = 20;

        // reset configuration: 160x120 at factor 2
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h0000_FFFF);

        // zero sizes and factor act as 1x1 at factor 2, column counter
        // is beyond the new width so every pixel ends the frame
        configure('0, '0, '0);
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'h5555_5555);

        // oversize sizes and factor clamp to 1024x1024 at factor 8,
        // the unmapped register slot must change nothing
        configure(11'h7FF, 11'h7FF, 11'd15);
        write_reg(REG_UNMAPPED, 11'h7FF);
        close_writes();
        send_pixel(32'h8000_0001);
        send_pixel(32'h7FFF_FFFE);
        send_pixel(32'h1234_5678);

        // shrink mid-frame: column counter at 3 wraps against width 3,
        // factor 1 is raised to 2, then the rest of that frame and one line
        // of the next
        configure(11'd3, 11'd2, 11'd1);
        repeat (7) send_pixel(random_pixel());

        // just past the limits, factor 9 held at 8
        configure(11'd1025, 11'd1025, 11'd9);
        repeat (2) send_pixel(random_pixel());

        // mid-range factor over a small frame
        configure(11'd4, 11'd3, 11'd5);
        repeat (6) send_pixel(random_pixel());

        // random phases, each starting from a drained block
        sent = 23;
        while (sent < PIXEL_TARGET) begin
            wait_for_drain();
            if (sent >= PIXEL_TARGET - QUIET_TAIL) begin
                push_gap_pct  = 0;
                pop_stall_pct = 0;
            end
            else begin
                case ($urandom_range(0, 2))
                    0:       push_gap_pct = 0;
                    1:       push_gap_pct = 15;
                    default: push_gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       pop_stall_pct = 0;
                    1:       pop_stall_pct = 15;
                    default: pop_stall_pct = 40;
                endcase
            end

            // any subset of the registers, leaving the frame position alone
            if ($urandom_range(0, 9) < 7)
                write_reg(ipru_pkg::REG_SRC_WIDTH, random_extent());
            if ($urandom_range(0, 9) < 7)
                write_reg(ipru_pkg::REG_SRC_HEIGHT, random_extent());
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 9) < 3)
                    write_reg(ipru_pkg::REG_SCALE_FACTOR,
                              ipru_pkg::CFG_W'($urandom_range(0, 15)));
                else
                    write_reg(ipru_pkg::REG_SCALE_FACTOR,
                              ipru_pkg::CFG_W'($urandom_range(ipru_pkg::MIN_FACTOR, 4)));
            end
            if ($urandom_range(0, 19) == 0)
                write_reg(REG_UNMAPPED, ipru_pkg::CFG_W'($urandom_range(0, 2047)));
            close_writes();

            batch = $urandom_range(6, 24);
            if (batch > PIXEL_TARGET - sent)
                batch = PIXEL_TARGET - sent;
            repeat (batch) send_pixel(random_pixel());
            sent += batch;
        end

        // let the last writes out, then watch for strays
        wait_for_drain();
        repeat (16) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("** integer_pixel_replication_upscaler_unit: PASSED **");
        else
            $display("** integer_pixel_replication_upscaler_unit: FAILED **");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #10ms;
        $display("** integer_pixel_replication_upscaler_unit: FAILED **");
        $finish;
    end

endmodule
